FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the Feistel CBC encrypt unit.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/fcbe_pkg.sv
// Types, constants and round functions for the Feistel CBC encrypt unit.
// No dependencies.
`default_nettype none

package fcbe_pkg;

    localparam int BLK_W       = 32;
    localparam int HALF_W      = 16;
    localparam int CNT_W       = 4;
    localparam int PROG_W      = 48;
    localparam int SLOT_W      = 6;
    localparam int MAX_SLOTS   = 8;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 5;
    localparam int KEY_ROT_RIGHT = 5;
    localparam int KEY_ROT_LEFT  = 3;

    typedef enum logic [1:0] {
        REG_CIPHER_KEY = 2'd0,
        REG_OP_COUNT   = 2'd1,
        REG_OP_PROGRAM = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_XOR     = 2'd0,
        OP_ROTL    = 2'd1,
        OP_ROTR    = 2'd2,
        OP_INVALID = 2'd3
    } t_op;

    typedef struct packed {
        logic [BLK_W-1:0]  cipher_key;
        logic [CNT_W-1:0]  op_count;
        logic [PROG_W-1:0] op_program;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic step;
        logic odd_round;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic bad_program;
    } t_sts;

    function automatic logic [HALF_W-1:0] f_rotl16(input logic [HALF_W-1:0] x,
                                                   input logic [3:0] amt);
        logic [2*HALF_W-1:0] tmp;
        tmp = {x, x} << amt;
        return tmp[2*HALF_W-1:HALF_W];
    endfunction

    function automatic logic [HALF_W-1:0] f_rotr16(input logic [HALF_W-1:0] x,
                                                   input logic [3:0] amt);
        logic [2*HALF_W-1:0] tmp;
        tmp = {x, x} >> amt;
        return tmp[HALF_W-1:0];
    endfunction

    function automatic logic [HALF_W-1:0] f_round_fn(input logic [HALF_W-1:0] d,
                                                     input logic [HALF_W-1:0] k,
                                                     input logic [PROG_W-1:0] prog,
                                                     input logic [CNT_W-1:0] n_act);
        logic [HALF_W-1:0] dd;
        logic [HALF_W-1:0] kk;
        logic [SLOT_W-1:0] slot;
        dd = d;
        kk = k;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            slot = prog[SLOT_W*s +: SLOT_W];
            if (CNT_W'(s) < n_act) begin
                unique case (t_op'(slot[1:0]))
                    OP_XOR:     dd = dd ^ kk;
                    OP_ROTL:    dd = f_rotl16(dd, slot[5:2]);
                    OP_ROTR:    dd = f_rotr16(dd, slot[5:2]);
                    OP_INVALID: dd = dd;
                endcase
                kk = f_rotl16(f_rotr16(kk, 4'(KEY_ROT_RIGHT)), 4'(KEY_ROT_LEFT));
            end
        end
        return dd;
    endfunction

    function automatic logic f_has_invalid(input logic [PROG_W-1:0] prog,
                                           input logic [CNT_W-1:0] n_act);
        logic bad;
        bad = 1'b0;
        for (int s = 0; s < MAX_SLOTS; s++) begin
            if ((CNT_W'(s) < n_act) &&
                (t_op'(prog[SLOT_W*s +: 2]) == OP_INVALID)) begin
                bad = 1'b1;
            end
        end
        return bad;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fcbe_ifs.sv
// Word channel interfaces for the Feistel CBC encrypt unit: plaintext in, ciphertext out.
// Depends on fcbe_pkg for the field widths.
`default_nettype none

interface fcbe_blk_if import fcbe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BLK_W-1:0]  plain_block;
    logic              restart_chain;

    modport source (output valid, output plain_block, output restart_chain, input ready);
    modport sink   (input valid, input plain_block, input restart_chain, output ready);
endinterface

interface fcbe_res_if import fcbe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BLK_W-1:0]  cipher_block;
    logic              op_error;

    modport source (output valid, output cipher_block, output op_error, input ready);
    modport sink   (input valid, input cipher_block, input op_error, output ready);
endinterface

`default_nettype wire

FILE: sv/fcbe_cfg.sv
// APB-style configuration registers: cipher key, operation count and operation program.
// Depends on fcbe_pkg.
`default_nettype none

module fcbe_cfg import fcbe_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CIPHER_KEY: r_cfg.cipher_key <= pwdata[BLK_W-1:0];
                REG_OP_COUNT:   r_cfg.op_count   <= pwdata[CNT_W-1:0];
                REG_OP_PROGRAM: r_cfg.op_program <= pwdata[PROG_W-1:0];
                REG_NONE:       r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CIPHER_KEY: prdata = APB_DATA_W'(r_cfg.cipher_key);
            REG_OP_COUNT:   prdata = APB_DATA_W'(r_cfg.op_count);
            REG_OP_PROGRAM: prdata = APB_DATA_W'(r_cfg.op_program);
            REG_NONE:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/fcbe_ctrl.sv
// Controller for the Feistel CBC encrypt unit: accept, round sequencing and result hand-off.
// Depends on fcbe_pkg.
`default_nettype none

module fcbe_ctrl import fcbe_pkg::*; #(
    parameter int ROUNDS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_cmd      o_cmd
);

    localparam int RW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [RW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic          w_last;

    assign w_last      = (r_cnt == RW'(ROUNDS - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.odd_round = r_cnt[0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_sts.bad_program ? S_HOLD : S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (w_last) begin
                    n_state = S_HOLD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: sv/fcbe_dp.sv
// Datapath for the Feistel CBC encrypt unit: chain register, round register and result register.
// Depends on fcbe_pkg for the round function and the command and status types.
`default_nettype none

module fcbe_dp import fcbe_pkg::*; #(
    parameter int MAX_OPS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire t_cmd             i_cmd,
    input  wire logic [BLK_W-1:0] i_plain_block,
    input  wire logic             i_restart_chain,
    output t_sts                  o_sts,
    output logic      [BLK_W-1:0] o_cipher_block,
    output logic                  o_op_error
);

    logic [BLK_W-1:0]  r_chain;
    logic [BLK_W-1:0]  r_blk, n_blk;
    logic              r_err;
    logic [BLK_W-1:0]  r_cipher;
    logic              r_op_err;
    logic [CNT_W-1:0]  w_n_act;
    logic [BLK_W-1:0]  w_chain_in;
    logic [BLK_W-1:0]  w_rk;
    logic [HALF_W-1:0] w_k;
    logic [HALF_W-1:0] w_f;

    assign w_n_act = (i_cfg.op_count > CNT_W'(MAX_OPS)) ? CNT_W'(MAX_OPS) : i_cfg.op_count;
    assign o_sts.bad_program = f_has_invalid(i_cfg.op_program, w_n_act);
    assign w_chain_in = i_restart_chain ? '0 : r_chain;

    always_comb begin
        w_rk  = i_cfg.cipher_key ^ r_blk;
        w_k   = i_cmd.odd_round ? w_rk[BLK_W-1:HALF_W] : w_rk[HALF_W-1:0];
        w_f   = f_round_fn(r_blk[HALF_W-1:0], w_k, i_cfg.op_program, w_n_act);
        n_blk = {w_f ^ r_blk[BLK_W-1:HALF_W], r_blk[BLK_W-1:HALF_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (i_cmd.load) begin
            r_chain <= w_chain_in;
        end else if (i_cmd.commit && !r_err) begin
            r_chain <= r_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_blk <= w_chain_in ^ i_plain_block;
            r_err <= o_sts.bad_program;
        end else if (i_cmd.step) begin
            r_blk <= n_blk;
        end
        if (i_cmd.commit) begin
            r_cipher <= r_err ? '0 : r_blk;
            r_op_err <= r_err;
        end
    end

    assign o_cipher_block = r_cipher;
    assign o_op_error     = r_op_err;

endmodule

`default_nettype wire

FILE: sv/feistel_cbc_block_encrypt_unit.sv
// Top level of the Feistel CBC encrypt unit: configuration port, controller and datapath.
// Depends on fcbe_pkg, the channel interfaces, fcbe_cfg, fcbe_ctrl, fcbe_dp and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Encrypts one 32-bit word at a time with a Feistel network chained in CBC mode. A word
// is loaded into the round register, runs the ROUNDS Feistel rounds there, and is then
// committed to the result register together with the new chaining value. The round
// register loop allows only one word in flight, since each word needs the chaining value
// that the previous word leaves. A word whose active operation list holds an invalid code
// skips the rounds and returns zero with the error flag set. The next word is accepted
// while the previous result waits to be taken.
module feistel_cbc_block_encrypt_unit import fcbe_pkg::*; #(
    parameter int ROUNDS  = 16,
    parameter int MAX_OPS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    fcbe_blk_if.sink                   i_blk,
    fcbe_res_if.source                 o_res,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;

    fcbe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fcbe_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_blk.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_cmd       (w_cmd)
    );

    fcbe_dp #(
        .MAX_OPS (MAX_OPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .i_plain_block   (i_blk.plain_block),
        .i_restart_chain (i_blk.restart_chain),
        .o_sts           (w_sts),
        .o_cipher_block  (o_res.cipher_block),
        .o_op_error      (o_res.op_error)
    );

    assign i_blk.ready = w_in_ready;
    assign o_res.valid = w_out_valid;

    `ASSERT_IMPLIES(a_err_zero, i_clk, i_rst_n, o_res.valid && o_res.op_error, o_res.cipher_block == '0)
    `ASSERT_NEXT(a_busy_after_load, i_clk, i_rst_n, w_cmd.load, !w_in_ready)
    `ASSERT_IMPLIES(a_commit_free, i_clk, i_rst_n, w_cmd.commit, !o_res.valid || o_res.ready)

endmodule

`default_nettype wire
